@@ design/grid_velocity_gradient_stretching_macros.svh @@
// Assertion helpers for the stretching block
`ifndef GRID_VELOCITY_GRADIENT_STRETCHING_MACROS_SVH
`define GRID_VELOCITY_GRADIENT_STRETCHING_MACROS_SVH

// same-cycle implication
`define GVGS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gvgs check failed");

// next-cycle implication
`define GVGS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gvgs check failed");

`endif

@@ design/gvgs_pkg.sv @@
`default_nettype none
package gvgs_pkg;
    localparam int FRAC = 16;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_INV_X  = 3'd3;
    localparam logic [2:0] REG_INV_Y  = 3'd4;
    localparam logic [2:0] REG_INV_Z  = 3'd5;

    localparam int SIZE_W = 6;
    localparam int INV_W  = 31;

    typedef struct packed {
        logic       rd_vld;
        logic       rd_minus;
        logic [1:0] rd_ax;
        logic       vort_vld;
        logic       clr;
    } gvgs_ctl_t;
endpackage
`default_nettype wire

@@ design/gvgs_ram.sv @@
`default_nettype none
module gvgs_ram #(
    parameter int AW = 15,
    parameter int DW = 96
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ design/gvgs_dp.sv @@
`default_nettype none
module gvgs_dp
    import gvgs_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire gvgs_ctl_t             ctl,
    input  wire logic [3*W-1:0]        vel_q,
    input  wire logic [3*W-1:0]        vort_q,
    input  wire logic [INV_W-1:0]      inv_x,
    input  wire logic [INV_W-1:0]      inv_y,
    input  wire logic [INV_W-1:0]      inv_z,
    output logic signed [W-1:0]        stretch [3],
    output logic [W-2:0]               peak_grad,
    output logic [W-2:0]               peak_vort,
    output logic                       done
);
    localparam int DW = W + 1;
    localparam int PW = DW + INV_W + 1;
    localparam int MW = 2 * W;
    localparam int SW = MW + 2;

    logic signed [W-1:0]  plus_reg [3];
    logic signed [DW-1:0] diff_reg [3];
    logic signed [PW-1:0] prod_reg [3];
    logic signed [W-1:0]  g_reg [3];
    logic signed [W-1:0]  w_reg [3];
    logic signed [MW-1:0] gw_reg [3];
    logic signed [W-1:0]  stretch_reg [3];
    logic                 dv_reg, pv_reg, gv_reg, mv_reg, done_reg;
    logic [1:0]           dax_reg, pax_reg, gax_reg, max_reg;
    logic [W-2:0]         pg_reg, pv_peak_reg;

    logic [INV_W-1:0]     inv_sel;
    logic signed [W-1:0]  g_next [3];
    logic [W-2:0]         pg_next, pvk_next;
    logic signed [SW-1:0] gw_sum;
    logic signed [SW-1:0] gw_sh;

    function automatic logic signed [W-1:0] sat_p(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[W-1:0];
        else if (v < lo)
            return lo[W-1:0];
        else
            return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_s(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[W-1:0];
        else if (v < lo)
            return lo[W-1:0];
        else
            return v[W-1:0];
    endfunction

    function automatic logic [W-2:0] abs_sat(input logic signed [W-1:0] v);
        logic [W-1:0] n;
        n = ~v + 1'b1;
        if (!v[W-1])
            return v[W-2:0];
        else if (n[W-1])
            return {(W-1){1'b1}};
        else
            return n[W-2:0];
    endfunction

    always_comb
    begin
        case (pax_reg)
            2'd0:    inv_sel = inv_x;
            2'd1:    inv_sel = inv_y;
            default: inv_sel = inv_z;
        endcase
    end

    always_comb
    begin
        pg_next  = pg_reg;
        pvk_next = pv_peak_reg;
        for (int c = 0; c < 3; c++)
        begin
            g_next[c] = sat_p(prod_reg[c] >>> FRAC);
            if (abs_sat(g_next[c]) > pg_next)
                pg_next = abs_sat(g_next[c]);
            if (abs_sat(signed'(vort_q[c*W +: W])) > pvk_next)
                pvk_next = abs_sat(signed'(vort_q[c*W +: W]));
        end
        gw_sum = SW'(gw_reg[0]) + SW'(gw_reg[1]) + SW'(gw_reg[2]);
        gw_sh  = gw_sum >>> FRAC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg      <= 1'b0;
            pv_reg      <= 1'b0;
            gv_reg      <= 1'b0;
            mv_reg      <= 1'b0;
            done_reg    <= 1'b0;
            pg_reg      <= '0;
            pv_peak_reg <= '0;
        end
        else
        begin
            dv_reg   <= ctl.rd_vld && ctl.rd_minus;
            pv_reg   <= dv_reg;
            gv_reg   <= pv_reg;
            mv_reg   <= gv_reg;
            done_reg <= mv_reg && (max_reg == 2'd2);
            if (ctl.clr)
            begin
                pg_reg      <= '0;
                pv_peak_reg <= '0;
            end
            else
            begin
                if (pv_reg)
                    pg_reg <= pg_next;
                if (ctl.vort_vld)
                    pv_peak_reg <= pvk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dax_reg <= ctl.rd_ax;
        pax_reg <= dax_reg;
        gax_reg <= pax_reg;
        max_reg <= gax_reg;
        for (int c = 0; c < 3; c++)
        begin
            if (ctl.rd_vld && !ctl.rd_minus)
                plus_reg[c] <= vel_q[c*W +: W];
            if (ctl.rd_vld && ctl.rd_minus)
                diff_reg[c] <= DW'(plus_reg[c]) - DW'(signed'(vel_q[c*W +: W]));
            if (ctl.vort_vld)
                w_reg[c] <= vort_q[c*W +: W];
            prod_reg[c] <= PW'(diff_reg[c]) * PW'(signed'({1'b0, inv_sel}));
            g_reg[c]    <= g_next[c];
            gw_reg[c]   <= MW'(g_reg[c]) * MW'(w_reg[c]);
        end
        if (mv_reg)
            stretch_reg[max_reg] <= sat_s(gw_sh);
    end

    assign stretch   = stretch_reg;
    assign peak_grad = pg_reg;
    assign peak_vort = pv_peak_reg;
    assign done      = done_reg;
endmodule
`default_nettype wire

@@ design/grid_velocity_gradient_stretching.sv @@
// Channel  | Dir | Request contents
// s_axis   | in  | tuser opcode; tdata x,y,z, vel xyz, vort xyz, restart
// m_axis   | out | tdata stretch xyz, max_gradient, max_vorticity
// cfg      | in  | cfg_index register number, cfg_data value
//
// A write request makes one write to each of the two grid memories.
// A compute request makes six single-port reads of the velocity memory
// (plus/minus per axis), then runs the difference/scale/dot pipeline.
// Input is held off while a compute runs; a finished result waits in the
// datapath until the output register is free, and only then is the next request accepted.
// Reset: maxima clear, grid sizes 1, reciprocals 1.0; memories are not cleared.
`default_nettype none
module grid_velocity_gradient_stretching
    import gvgs_pkg::*;
#(
    parameter int MAX_DIM     = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // x_index, y_index, z_index, vel_x, vel_y, vel_z, vort_x, vort_y, vort_z, restart
    input  wire logic [207:0] s_axis_tdata,
    // opcode
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // stretch_x, stretch_y, stretch_z, max_gradient, max_vorticity, 2 pad bits
    output logic [159:0]      m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);
    localparam int W  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int AW = $clog2(MAX_DIM);
    localparam int MA = 3 * AW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [SIZE_W-1:0] size_reg [3];
    logic [INV_W-1:0]  inv_reg [3];
    logic [AW-1:0]     crd_reg [3];
    logic [AW-1:0]     lim_reg [3];
    logic              restart_reg;
    logic              mvalid_reg;
    logic [159:0]      mdata_reg;
    gvgs_ctl_t         ctl_reg;

    logic              acc, acc_wr, acc_cmp, wr_ok, out_free, done;
    logic [6:0]        icrd [3];
    logic [AW-1:0]     ccrd [3];
    logic [AW-1:0]     clim [3];
    logic [AW-1:0]     rcrd [3];
    logic [1:0]        rax;
    logic              rminus, issue;
    logic [3*W-1:0]    wr_vel, wr_vort, vel_q, vort_q;
    logic signed [W-1:0] stretch [3];
    logic [W-2:0]      peak_grad, peak_vort;

    function automatic logic [W-1:0] sat_in(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = {{(33-W){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[W-1:0];
        else if (v < lo)
            return lo[W-1:0];
        else
            return v[W-1:0];
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign acc_wr        = acc && (s_axis_tuser == OP_WRITE);
    assign acc_cmp       = acc && (s_axis_tuser == OP_COMPUTE);
    assign out_free      = !mvalid_reg || m_axis_tready;

    always_comb
    begin
        logic [6:0] n;
        logic [6:0] s;
        wr_ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            icrd[a] = 7'(s_axis_tdata[a*5 +: 5]);
            if (icrd[a] >= 7'(MAX_DIM))
                wr_ok = 1'b0;
            s = 7'(size_reg[a]);
            if (s == 7'd0)
                n = 7'd1;
            else if (s > 7'(MAX_DIM))
                n = 7'(MAX_DIM);
            else
                n = s;
            clim[a] = AW'(n - 7'd1);
            ccrd[a] = (icrd[a] > (n - 7'd1)) ? clim[a] : icrd[a][AW-1:0];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            wr_vel[c*W +: W]  = sat_in(s_axis_tdata[15 + c*32 +: 32]);
            wr_vort[c*W +: W] = sat_in(s_axis_tdata[111 + c*32 +: 32]);
        end
    end

    // neighbour address for the current read slot
    always_comb
    begin
        rax    = cnt_reg[2:1];
        rminus = cnt_reg[0];
        issue  = (state_reg == ST_RUN);
        for (int a = 0; a < 3; a++)
        begin
            rcrd[a] = crd_reg[a];
            if (rax == 2'(a))
            begin
                if (rminus)
                    rcrd[a] = (crd_reg[a] != '0) ? crd_reg[a] - 1'b1 : crd_reg[a];
                else
                    rcrd[a] = (crd_reg[a] < lim_reg[a]) ? crd_reg[a] + 1'b1 : crd_reg[a];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (acc_cmp)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
            ctl_reg    <= '0;
            for (int a = 0; a < 3; a++)
            begin
                size_reg[a] <= SIZE_W'(1);
                inv_reg[a]  <= INV_W'(65536);
            end
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            ctl_reg.rd_vld   <= issue;
            ctl_reg.rd_minus <= rminus;
            ctl_reg.rd_ax    <= rax;
            ctl_reg.vort_vld <= issue && (cnt_reg == 3'd0);
            ctl_reg.clr      <= acc_cmp && restart_in();
            if (state_reg == ST_HOLD && out_free)
                mvalid_reg <= 1'b1;
            else if (m_axis_tready)
                mvalid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SIZE_X: size_reg[0] <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_Y: size_reg[1] <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_Z: size_reg[2] <= cfg_data[SIZE_W-1:0];
                    REG_INV_X:  inv_reg[0]  <= cfg_data;
                    REG_INV_Y:  inv_reg[1]  <= cfg_data;
                    REG_INV_Z:  inv_reg[2]  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    function automatic logic restart_in();
        return s_axis_tdata[207];
    endfunction

    always_ff @(posedge clk)
    begin
        if (acc_cmp)
        begin
            crd_reg     <= ccrd;
            lim_reg     <= clim;
            restart_reg <= s_axis_tdata[207];
        end
        if (state_reg == ST_HOLD && out_free)
        begin
            for (int c = 0; c < 3; c++)
                mdata_reg[c*32 +: 32] <= 32'(stretch[c]);
            mdata_reg[126:96]  <= 31'(peak_grad);
            mdata_reg[157:127] <= 31'(peak_vort);
            mdata_reg[159:158] <= 2'b00;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    gvgs_ram #(.AW(MA), .DW(3*W)) u_vel (
        .clk   (clk),
        .we    (acc_wr && wr_ok),
        .waddr ({icrd[2][AW-1:0], icrd[1][AW-1:0], icrd[0][AW-1:0]}),
        .wdata (wr_vel),
        .re    (issue),
        .raddr ({rcrd[2], rcrd[1], rcrd[0]}),
        .rdata (vel_q)
    );

    gvgs_ram #(.AW(MA), .DW(3*W)) u_vort (
        .clk   (clk),
        .we    (acc_wr && wr_ok),
        .waddr ({icrd[2][AW-1:0], icrd[1][AW-1:0], icrd[0][AW-1:0]}),
        .wdata (wr_vort),
        .re    (issue && (cnt_reg == 3'd0)),
        .raddr ({crd_reg[2], crd_reg[1], crd_reg[0]}),
        .rdata (vort_q)
    );

    gvgs_dp #(.W(W)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_reg),
        .vel_q     (vel_q),
        .vort_q    (vort_q),
        .inv_x     (inv_reg[0]),
        .inv_y     (inv_reg[1]),
        .inv_z     (inv_reg[2]),
        .stretch   (stretch),
        .peak_grad (peak_grad),
        .peak_vort (peak_vort),
        .done      (done)
    );

`include "grid_velocity_gradient_stretching_macros.svh"

    `GVGS_ASSERT_IMP(a_done_in_drain, done, state_reg == ST_DRAIN)
    `GVGS_ASSERT_NXT(a_cmp_starts, acc_cmp, state_reg == ST_RUN && cnt_reg == 3'd0)
    `GVGS_ASSERT_NXT(a_hold_loads, state_reg == ST_HOLD && out_free, m_axis_tvalid)
    `GVGS_ASSERT_IMP(a_clr_restart, ctl_reg.clr, restart_reg && state_reg == ST_RUN)
endmodule
`default_nettype wire

@@ tb/sv/gvgs_checker.sv @@
`timescale 1ns / 1ps
module gvgs_checker
    import gvgs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [207:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [159:0] m_axis_tdata,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [30:0]  cfg_data,
    output int                mismatches,
    output int                pending
);
    localparam int DIM = 32;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic [30:0]        grad_max;
        logic [30:0]        vort_max;
    } stretch_t;

    stretch_t            stretch_due[$];
    logic signed [31:0]  vel_mem [3][DIM*DIM*DIM];
    logic signed [31:0]  vort_mem[3][DIM*DIM*DIM];
    logic [SIZE_W-1:0]   grid_size[3];
    logic [INV_W-1:0]    inv_two_d[3];
    logic [30:0]         grad_peak;
    logic [30:0]         vort_peak;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -68'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] a;
        a = v[31] ? -v : v;
        return a[31] ? 31'h7FFFFFFF : a[30:0];
    endfunction

    function automatic int eff_size(input logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > DIM)
            return DIM;
        return s;
    endfunction

    function automatic int cell_addr(input int x, input int y, input int z);
        return (z * DIM + y) * DIM + x;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic predict_stretch(input logic [207:0] d);
        int                 ctr[3];
        int                 lim[3];
        int                 hi[3];
        int                 lo[3];
        int                 pa;
        int                 ma;
        int                 cc;
        longint             diff;
        longint             prod;
        logic signed [31:0] g[3][3];
        logic signed [31:0] w[3];
        logic signed [67:0] acc;
        logic signed [31:0] st[3];
        stretch_t           r;
        ctr[0] = d[4:0];
        ctr[1] = d[9:5];
        ctr[2] = d[14:10];
        for (int a = 0; a < 3; a++)
        begin
            lim[a] = eff_size(grid_size[a]);
            if (ctr[a] > lim[a] - 1)
                ctr[a] = lim[a] - 1;
        end
        if (d[207])
        begin
            grad_peak = '0;
            vort_peak = '0;
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            hi = ctr;
            lo = ctr;
            if (ctr[ax] + 1 < lim[ax])
                hi[ax] = ctr[ax] + 1;
            if (ctr[ax] > 0)
                lo[ax] = ctr[ax] - 1;
            pa = cell_addr(hi[0], hi[1], hi[2]);
            ma = cell_addr(lo[0], lo[1], lo[2]);
            for (int comp = 0; comp < 3; comp++)
            begin
                diff = longint'(vel_mem[comp][pa]) - longint'(vel_mem[comp][ma]);
                prod = diff * longint'({1'b0, inv_two_d[ax]});
                g[comp][ax] = sat32(prod >>> 16);
                if (mag31(g[comp][ax]) > grad_peak)
                    grad_peak = mag31(g[comp][ax]);
            end
        end
        cc = cell_addr(ctr[0], ctr[1], ctr[2]);
        for (int n = 0; n < 3; n++)
        begin
            w[n] = vort_mem[n][cc];
            if (mag31(w[n]) > vort_peak)
                vort_peak = mag31(w[n]);
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            acc = '0;
            for (int comp = 0; comp < 3; comp++)
                acc = acc + g[comp][ax] * w[comp];
            st[ax] = sat32(acc >>> 16);
        end
        r.sx = st[0];
        r.sy = st[1];
        r.sz = st[2];
        r.grad_max = grad_peak;
        r.vort_max = vort_peak;
        stretch_due.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stretch_t exp_r;
        int       a;
        if (!rst_n)
        begin
            stretch_due.delete();
            grad_peak = '0;
            vort_peak = '0;
            for (int i = 0; i < 3; i++)
            begin
                grid_size[i] = 1;
                inv_two_d[i] = 65536;
            end
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIZE_X: grid_size[0] = cfg_data[SIZE_W-1:0];
                    REG_SIZE_Y: grid_size[1] = cfg_data[SIZE_W-1:0];
                    REG_SIZE_Z: grid_size[2] = cfg_data[SIZE_W-1:0];
                    REG_INV_X:  inv_two_d[0] = cfg_data;
                    REG_INV_Y:  inv_two_d[1] = cfg_data;
                    REG_INV_Z:  inv_two_d[2] = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (stretch_due.size() == 0)
                begin
                    $display("%0t: result with none outstanding", $realtime);
                    mismatches++;
                end
                else
                begin
                    exp_r = stretch_due.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.sx)
                        report("stretch_x", m_axis_tdata[31:0], exp_r.sx);
                    if (m_axis_tdata[63:32] !== exp_r.sy)
                        report("stretch_y", m_axis_tdata[63:32], exp_r.sy);
                    if (m_axis_tdata[95:64] !== exp_r.sz)
                        report("stretch_z", m_axis_tdata[95:64], exp_r.sz);
                    if (m_axis_tdata[126:96] !== exp_r.grad_max)
                        report("max_gradient", m_axis_tdata[126:96], exp_r.grad_max);
                    if (m_axis_tdata[157:127] !== exp_r.vort_max)
                        report("max_vorticity", m_axis_tdata[157:127], exp_r.vort_max);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_WRITE)
                begin
                    a = cell_addr(s_axis_tdata[4:0], s_axis_tdata[9:5], s_axis_tdata[14:10]);
                    vel_mem[0][a]  = s_axis_tdata[46:15];
                    vel_mem[1][a]  = s_axis_tdata[78:47];
                    vel_mem[2][a]  = s_axis_tdata[110:79];
                    vort_mem[0][a] = s_axis_tdata[142:111];
                    vort_mem[1][a] = s_axis_tdata[174:143];
                    vort_mem[2][a] = s_axis_tdata[206:175];
                end
                else
                    predict_stretch(s_axis_tdata);
            end
            pending = stretch_due.size();
        end
    end
endmodule

@@ tb/sv/tb_grid_velocity_gradient_stretching.sv @@
`timescale 1ns / 1ps
module tb_grid_velocity_gradient_stretching;
    import gvgs_pkg::*;

    typedef struct {
        int sx;
        int sy;
        int sz;
        int ix;
        int iy;
        int iz;
    } phase_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_data;
    int           mismatches;
    int           pending;

    bit           no_gaps;
    bit           rx_no_stall;
    bit           hold_req;
    int           cur_size[3];

    // -1 picks a random reciprocal
    phase_t plan[7] = '{
        '{4, 3, 5, -1, -1, -1},
        '{32, 1, 1, 65536, 65536, 65536},
        '{1, 32, 2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
        '{0, 63, 1, 0, -1, 0},
        '{3, 3, 3, -1, -1, -1},
        '{2, 1, 32, -1, 1, 65536},
        '{5, 5, 2, -1, -1, -1}
    };

    grid_velocity_gradient_stretching u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gvgs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                n = rx_no_stall ? 0 : $urandom_range(0, 17);
                if (n > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    function automatic int eff_size(input int s);
        if (s == 0)
            return 1;
        if (s > 32)
            return 32;
        return s;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic op, input logic [207:0] d);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic store_point(input int x, input int y, input int z,
                               input logic [31:0] vel, input logic [31:0] vort,
                               input bit rnd, input logic rs);
        logic [31:0] v[6];
        for (int i = 0; i < 6; i++)
            v[i] = rnd ? pick_value() : (i < 3 ? vel : vort);
        send(OP_WRITE, {rs, v[5], v[4], v[3], v[2], v[1], v[0],
                        5'(z), 5'(y), 5'(x)});
    endtask

    task automatic compute_point(input int x, input int y, input int z, input logic rs);
        send(OP_COMPUTE, {rs, 192'($urandom) << 64 | 192'($urandom), 5'(z), 5'(y), 5'(x)});
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[30:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_phase(input phase_t p);
        int inv[3];
        inv = '{p.ix, p.iy, p.iz};
        for (int i = 0; i < 3; i++)
            if (inv[i] < 0)
                inv[i] = $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                              : ($urandom & 32'h7FFFFFFF);
        settle();
        write_reg(REG_SIZE_X, p.sx);
        write_reg(REG_SIZE_Y, p.sy);
        write_reg(REG_SIZE_Z, p.sz);
        write_reg(REG_INV_X, inv[0]);
        write_reg(REG_INV_Y, inv[1]);
        write_reg(REG_INV_Z, inv[2]);
        cur_size = '{eff_size(p.sx), eff_size(p.sy), eff_size(p.sz)};
    endtask

    task automatic random_traffic(input int k);
        int c[3];
        for (int n = 0; n < 60; n++)
        begin
            if (k == 3 && n == 40)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) < 6)
            begin
                for (int a = 0; a < 3; a++)
                    c[a] = $urandom_range(0, 1) ? $urandom_range(0, cur_size[a] - 1)
                                                : $urandom_range(0, 31);
                compute_point(c[0], c[1], c[2], $urandom_range(0, 9) == 0);
            end
            else
                store_point($urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 31), 0, 0, 1'b1, $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        logic [31:0] v;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SIZE_X;
        cfg_data      = '0;
        no_gaps       = 1'b0;
        rx_no_stall   = 1'b0;
        hold_req      = 1'b0;
        cur_size      = '{1, 1, 1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: single point, zero gradients, clamped coordinates
        store_point(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0);
        store_point(31, 31, 31, 32'h80000000, 32'h80000000, 1'b0, 1'b1);
        compute_point(0, 0, 0, 1'b1);
        compute_point(31, 5, 7, 1'b0);

        // 2x2x2 with full-scale values and extreme reciprocals
        apply_phase('{2, 2, 2, 32'h7FFFFFFF, 0, 65536});
        for (int i = 0; i < 8; i++)
        begin
            v = ((i & 1) ^ ((i >> 1) & 1) ^ (i >> 2)) ? 32'h7FFFFFFF : 32'h80000000;
            store_point(i & 1, (i >> 1) & 1, i >> 2, v, ~v, 1'b0, 1'b0);
        end
        compute_point(0, 0, 0, 1'b0);
        compute_point(1, 1, 1, 1'b0);
        compute_point(31, 31, 31, 1'b1);
        compute_point(1, 0, 1, 1'b0);
        compute_point(0, 1, 0, 1'b1);

        for (int k = 0; k < 7; k++)
        begin
            apply_phase(plan[k]);
            no_gaps     = (k == 1);
            rx_no_stall = (k == 1 || k == 4);
            for (int z = 0; z < cur_size[2]; z++)
                for (int y = 0; y < cur_size[1]; y++)
                    for (int x = 0; x < cur_size[0]; x++)
                        store_point(x, y, z, 0, 0, 1'b1, 1'b0);
            if (k == 2)
                hold_req = 1'b1;
            random_traffic(k);
        end

        settle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
